[hw/rtl/control_chart_rule_monitor_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the control chart rule monitor.
// Each macro checks a property on the rising edge of clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONTROL_CHART_RULE_MONITOR_TOP_ASSERT_SVH
`define CONTROL_CHART_RULE_MONITOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCRM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ccrm_pkg.sv]
// ----------------------------------------------------------------------------
// ccrm_pkg
// Types and constants shared by the control chart rule monitor modules.
// ----------------------------------------------------------------------------
package ccrm_pkg;

  localparam int SAMPLE_BITS   = 32;
  localparam int RUN_LEN_BITS  = 5;
  localparam int RULE_COUNT    = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [RUN_LEN_BITS-1:0] SIDE_RUN_RESET      = 5'd9;
  localparam logic [RUN_LEN_BITS-1:0] TREND_RUN_RESET     = 5'd6;
  localparam logic [RUN_LEN_BITS-1:0] ALTERNATE_RUN_RESET = 5'd14;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_UPPER_LIMIT    = 3'd0,
    CFG_LOWER_LIMIT    = 3'd1,
    CFG_CENTER_LINE    = 3'd2,
    CFG_SIDE_RUN_LEN   = 3'd3,
    CFG_TREND_RUN_LEN  = 3'd4,
    CFG_ALT_RUN_LEN    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first_of_set;
  } in_item_t;

  typedef struct packed {
    logic                  limit_hit;
    logic                  side_run_hit;
    logic                  trend_hit;
    logic                  alternate_hit;
    logic [RULE_COUNT-1:0] alarm_flags;
  } out_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] upper_limit;
    logic signed [SAMPLE_BITS-1:0] lower_limit;
    logic signed [SAMPLE_BITS-1:0] center_line;
    logic [RUN_LEN_BITS-1:0]       side_run_length;
    logic [RUN_LEN_BITS-1:0]       trend_run_length;
    logic [RUN_LEN_BITS-1:0]       alternate_run_length;
  } cfg_t;

endpackage

[hw/rtl/ccrm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ccrm_cfg_regs
// Configuration register file: limits, centre line and run lengths.
// ----------------------------------------------------------------------------
module ccrm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ccrm_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [ccrm_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output ccrm_pkg::cfg_t                     cfg
);
  import ccrm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_limit          <= '0;
      cfg_r.lower_limit          <= '0;
      cfg_r.center_line          <= '0;
      cfg_r.side_run_length      <= SIDE_RUN_RESET;
      cfg_r.trend_run_length     <= TREND_RUN_RESET;
      cfg_r.alternate_run_length <= ALTERNATE_RUN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_UPPER_LIMIT:   cfg_r.upper_limit <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_LOWER_LIMIT:   cfg_r.lower_limit <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_CENTER_LINE:   cfg_r.center_line <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_SIDE_RUN_LEN:  cfg_r.side_run_length <= cfg_wdata[RUN_LEN_BITS-1:0];
        CFG_TREND_RUN_LEN: cfg_r.trend_run_length <= cfg_wdata[RUN_LEN_BITS-1:0];
        CFG_ALT_RUN_LEN:   cfg_r.alternate_run_length <= cfg_wdata[RUN_LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/ccrm_rule_core.sv]
// ----------------------------------------------------------------------------
// ccrm_rule_core
// Run-rule state and the single-pass evaluation of the four chart rules.
// ----------------------------------------------------------------------------
module ccrm_rule_core #(
  parameter int COUNT_BITS = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  ccrm_pkg::in_item_t  item,
  input  ccrm_pkg::cfg_t      cfg,
  output ccrm_pkg::out_item_t result
);
  import ccrm_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_TWO = COUNT_BITS'(2);

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic reached(input logic [COUNT_BITS-1:0] c,
                                   input logic [RUN_LEN_BITS-1:0] len);
    reached = {{RUN_LEN_BITS{1'b0}}, c} >= {{COUNT_BITS{1'b0}}, len};
  endfunction

  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic                          have_dir_r, have_dir_nxt;
  logic                          last_up_r, last_up_nxt;
  logic [COUNT_BITS-1:0]         above_r, above_nxt;
  logic [COUNT_BITS-1:0]         below_r, below_nxt;
  logic [COUNT_BITS-1:0]         rise_r, rise_nxt;
  logic [COUNT_BITS-1:0]         fall_r, fall_nxt;
  logic [COUNT_BITS-1:0]         alt_r, alt_nxt;
  logic [RULE_COUNT-1:0]         sticky_r, sticky_nxt;

  // State as seen by this sample: a new data set starts from the cleared values.
  logic                  hp, hd, lu;
  logic [COUNT_BITS-1:0] above_c, below_c, rise_c, fall_c, alt_c;
  logic [RULE_COUNT-1:0] sticky_c;
  logic                  up, down, gt_c, lt_c;
  logic                  limit_hit, side_hit, trend_hit, alt_hit;

  always_comb begin
    hp       = item.first_of_set ? 1'b0 : have_prev_r;
    hd       = item.first_of_set ? 1'b0 : have_dir_r;
    lu       = item.first_of_set ? 1'b0 : last_up_r;
    above_c  = item.first_of_set ? '0 : above_r;
    below_c  = item.first_of_set ? '0 : below_r;
    rise_c   = item.first_of_set ? CNT_ONE : rise_r;
    fall_c   = item.first_of_set ? CNT_ONE : fall_r;
    alt_c    = item.first_of_set ? CNT_ONE : alt_r;
    sticky_c = item.first_of_set ? '0 : sticky_r;

    limit_hit = (item.sample > cfg.upper_limit) || (item.sample < cfg.lower_limit);

    gt_c = item.sample > cfg.center_line;
    lt_c = item.sample < cfg.center_line;
    above_nxt = above_c;
    below_nxt = below_c;
    if (gt_c) begin
      above_nxt = sat_inc(above_c);
      below_nxt = '0;
    end else if (lt_c) begin
      below_nxt = sat_inc(below_c);
      above_nxt = '0;
    end
    side_hit = reached(above_nxt, cfg.side_run_length) ||
               reached(below_nxt, cfg.side_run_length);

    up   = item.sample > prev_r;
    down = item.sample < prev_r;
    rise_nxt    = rise_c;
    fall_nxt    = fall_c;
    alt_nxt     = alt_c;
    have_dir_nxt = hd;
    last_up_nxt = lu;
    trend_hit   = 1'b0;
    alt_hit     = 1'b0;
    if (hp) begin
      rise_nxt = up ? sat_inc(rise_c) : CNT_ONE;
      fall_nxt = down ? sat_inc(fall_c) : CNT_ONE;
      trend_hit = reached(rise_nxt, cfg.trend_run_length) ||
                  reached(fall_nxt, cfg.trend_run_length);
      // A change of direction extends the alternation; a repeat restarts it at two.
      if (hd && (up != lu)) begin
        alt_nxt = sat_inc(alt_c);
      end else begin
        alt_nxt = CNT_TWO;
      end
      have_dir_nxt = 1'b1;
      last_up_nxt  = up;
      alt_hit = reached(alt_nxt, cfg.alternate_run_length);
    end

    prev_nxt      = item.sample;
    have_prev_nxt = 1'b1;
    sticky_nxt    = sticky_c | {alt_hit, trend_hit, side_hit, limit_hit};

    result.limit_hit     = limit_hit;
    result.side_run_hit  = side_hit;
    result.trend_hit     = trend_hit;
    result.alternate_hit = alt_hit;
    result.alarm_flags   = sticky_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      have_dir_r  <= 1'b0;
      last_up_r   <= 1'b0;
      above_r     <= '0;
      below_r     <= '0;
      rise_r      <= CNT_ONE;
      fall_r      <= CNT_ONE;
      alt_r       <= CNT_ONE;
      sticky_r    <= '0;
    end else if (step_en) begin
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      have_dir_r  <= have_dir_nxt;
      last_up_r   <= last_up_nxt;
      above_r     <= above_nxt;
      below_r     <= below_nxt;
      rise_r      <= rise_nxt;
      fall_r      <= fall_nxt;
      alt_r       <= alt_nxt;
      sticky_r    <= sticky_nxt;
    end
  end

endmodule

[hw/rtl/control_chart_rule_monitor_top.sv]
// ----------------------------------------------------------------------------
// control_chart_rule_monitor_top
// The monitor takes one signed Q16.16 sample per item and returns one result
// per item with the hits of four control chart rules (outside the limits, a
// same-side run, a rising or falling trend, an up/down alternation) and the
// sticky alarm bits of the current data set. An item with first_of_set high
// clears all run state and alarms before it is evaluated. The block takes one
// item every cycle while the result channel is not stalled; an accepted item
// is captured in the input register, and its result is then loaded into the
// result register, from which it is offered on the result channel. The rule
// evaluation between the two registers is short compare and counter logic,
// and both registers advance together, which is what allows one item per
// cycle.
// Configuration is written through a simple write port and should only change
// while no items are in flight.
// ----------------------------------------------------------------------------
`include "control_chart_rule_monitor_top_assert.svh"

module control_chart_rule_monitor_top #(
  parameter int COUNT_BITS = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ccrm_pkg::in_item_t                 in_data,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output ccrm_pkg::out_item_t                out_data,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [ccrm_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [ccrm_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import ccrm_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_data_r;
  logic      s1_valid_r;
  logic      s1_adv;
  logic      in_accept;
  out_item_t result;
  out_item_t out_data_r;
  logic      out_valid_r;

  ccrm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The input register moves on whenever the result register is empty or its
  // current result is being taken this cycle.
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
  end

  // The rule state advances exactly once per item, as it leaves the input
  // register for the result register.
  ccrm_rule_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_valid_r && s1_adv),
    .item    (s1_data_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted item always lands in the input register.
  `CCRM_ASSERT_NEXT(a_accept_lands, in_accept, s1_valid_r, "accepted item was dropped")

  // The first item of a set reports exactly its own hits as alarms.
  `CCRM_ASSERT_NEXT(a_first_alarms, s1_valid_r && s1_adv && s1_data_r.first_of_set,
    out_data_r.alarm_flags == {out_data_r.alternate_hit, out_data_r.trend_hit,
    out_data_r.side_run_hit, out_data_r.limit_hit}, "alarms not cleared at set start")

  // Sticky alarms always include the hits of the same result.
  `CCRM_ASSERT_SAME(a_sticky_cover, out_valid_r,
    (out_data_r.alarm_flags & {out_data_r.alternate_hit, out_data_r.trend_hit,
    out_data_r.side_run_hit, out_data_r.limit_hit}) == {out_data_r.alternate_hit,
    out_data_r.trend_hit, out_data_r.side_run_hit, out_data_r.limit_hit},
    "alarm flags miss a current hit")

endmodule
